### hw/rtl/strided_tensor_transpose_defines.svh
// Assertion macros shared by the strided tensor transpose RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef STRIDED_TENSOR_TRANSPOSE_DEFINES_SVH
`define STRIDED_TENSOR_TRANSPOSE_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked property that is switched off while reset is asserted.
`define STT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define STT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define STT_ASSERT(lbl, clk, rst_n, prop, msg)
`define STT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### hw/rtl/stt_pkg.sv
`timescale 1ns / 1ps
// Types, constants and helper functions for the strided tensor transpose.
// Used by every module of the block; depends on nothing.
package stt_pkg;

  localparam int unsigned NUM_DIMS  = 4;
  localparam int unsigned BUF_DEPTH = 4096;
  localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);
  localparam int unsigned LP_W      = $clog2(BUF_DEPTH + 1);
  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned CNT_W     = $clog2(MAX_DIM);
  localparam int unsigned STRIDE_W  = 12;
  localparam int unsigned PROD_W    = CNT_W + STRIDE_W;
  localparam int unsigned ADDR_W    = PROD_W + $clog2(NUM_DIMS);
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_FETCH  = 2'd1,
    FUNC_REWIND = 2'd2
  } func_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DIM_SIZE_0 = 3'd0,
    REG_DIM_SIZE_1 = 3'd1,
    REG_DIM_SIZE_2 = 3'd2,
    REG_DIM_SIZE_3 = 3'd3,
    REG_STRIDE_0   = 3'd4,
    REG_STRIDE_1   = 3'd5,
    REG_STRIDE_2   = 3'd6,
    REG_STRIDE_3   = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [NUM_DIMS-1:0][DIM_W-1:0]    dim_size;
    logic [NUM_DIMS-1:0][STRIDE_W-1:0] stride;
  } stt_cfg_t;

  typedef struct packed {
    logic step;
    logic clear;
  } stt_ctrl_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              last;
  } stt_addr_t;

  // A size of zero counts as one, anything above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] size);
    logic [DIM_W-1:0] res;
    if (size == '0) begin
      res = DIM_W'(1);
    end else if (size > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = size;
    end
    return res;
  endfunction

endpackage

### hw/rtl/stt_buffer.sv
`timescale 1ns / 1ps
// Tensor byte buffer: one write port, one read port with registered data.
// Depends on stt_pkg for depth and widths.
module stt_buffer (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [stt_pkg::BUF_AW-1:0]  waddr_i,
  input  logic [stt_pkg::DATA_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [stt_pkg::BUF_AW-1:0]  raddr_i,
  output logic [stt_pkg::DATA_W-1:0]  rdata_o
);

  logic [stt_pkg::DATA_W-1:0] mem [stt_pkg::BUF_DEPTH];
  logic [stt_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/stt_addr_gen.sv
`timescale 1ns / 1ps
// Loop counters and source address generation for fetch items.
// Depends on stt_pkg for the config, control and address structs.
module stt_addr_gen (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stt_pkg::stt_ctrl_t  ctrl_i,
  input  stt_pkg::stt_cfg_t   cfg_i,
  output stt_pkg::stt_addr_t  addr_o
);

  logic [stt_pkg::CNT_W-1:0]  cnt_q  [stt_pkg::NUM_DIMS];
  logic [stt_pkg::CNT_W-1:0]  cnt_d  [stt_pkg::NUM_DIMS];
  logic [stt_pkg::PROD_W-1:0] prod_q [stt_pkg::NUM_DIMS];
  logic                       last_q;
  logic                       wrap_d;
  logic [stt_pkg::ADDR_W-1:0] sum;

  // Innermost counter steps first; the carry ripples outward.
  always_comb begin
    logic                      carry;
    logic [stt_pkg::DIM_W-1:0] nxt;
    carry = 1'b1;
    for (int k = stt_pkg::NUM_DIMS - 1; k >= 0; k--) begin
      cnt_d[k] = cnt_q[k];
      nxt      = stt_pkg::DIM_W'(cnt_q[k]) + stt_pkg::DIM_W'(1);
      if (carry) begin
        if (nxt >= stt_pkg::eff_size(cfg_i.dim_size[k])) begin
          cnt_d[k] = '0;
        end else begin
          cnt_d[k] = nxt[stt_pkg::CNT_W-1:0];
          carry    = 1'b0;
        end
      end
    end
    wrap_d = carry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < stt_pkg::NUM_DIMS; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int k = 0; k < stt_pkg::NUM_DIMS; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (ctrl_i.step) begin
      for (int k = 0; k < stt_pkg::NUM_DIMS; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  // Products of the counters as they stood before the step.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      for (int k = 0; k < stt_pkg::NUM_DIMS; k++) begin
        prod_q[k] <= stt_pkg::PROD_W'(cnt_q[k]) * stt_pkg::PROD_W'(cfg_i.stride[k]);
      end
      last_q <= wrap_d;
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < stt_pkg::NUM_DIMS; k++) begin
      sum = sum + stt_pkg::ADDR_W'(prod_q[k]);
    end
  end

  assign addr_o.addr = sum;
  assign addr_o.last = last_q;

endmodule

### hw/rtl/strided_tensor_transpose.sv
`timescale 1ns / 1ps
// Top level of the strided tensor transpose: config registers, load pointer,
// fetch sequencer and output register. Depends on stt_pkg, stt_buffer,
// stt_addr_gen and strided_tensor_transpose_defines.svh.
//
// A load or rewind item is done when it is accepted and busy stays low. A
// fetch item keeps busy high while it passes through ST_SUM (sum of the
// registered address products, range check and buffer read) and ST_READ
// (the output register load); its result shows on valid_o in the cycle
// after ST_READ, when the next item may already be accepted. The result
// is held for exactly that one cycle; the receiver must take it then, since
// the block has no way to be stalled on its output. After reset and after a
// rewind the buffer counts as empty.
`include "strided_tensor_transpose_defines.svh"

module strided_tensor_transpose (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [stt_pkg::FUNC_W-1:0]          func_i,
  input  logic signed [stt_pkg::DATA_W-1:0]   data_in_i,
  output logic                                valid_o,
  output logic signed [stt_pkg::DATA_W-1:0]   data_out_o,
  output logic                                last_o,
  output logic                                range_error_o,
  input  logic                                cfg_we_i,
  input  logic [stt_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [stt_pkg::DIM_W-1:0]           cfg_data_i
);

  stt_pkg::stt_cfg_t          cfg_q;
  stt_pkg::stt_ctrl_t         ctrl;
  stt_pkg::stt_addr_t         gen_addr;
  stt_pkg::state_e            state_q, state_d;
  logic [stt_pkg::LP_W-1:0]   load_ptr_q;
  logic                       accept;
  logic                       load_we;
  logic                       rd_en;
  logic                       err_d, err_q, last_q;
  logic [stt_pkg::DATA_W-1:0] rdata;
  logic                       valid_q;
  logic [stt_pkg::DATA_W-1:0] data_q;
  logic                       out_last_q, out_err_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < stt_pkg::NUM_DIMS; k++) begin
        cfg_q.dim_size[k] <= stt_pkg::DIM_W'(1);
        cfg_q.stride[k]   <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (stt_pkg::reg_e'(cfg_idx_i))
        stt_pkg::REG_DIM_SIZE_0: cfg_q.dim_size[0] <= cfg_data_i;
        stt_pkg::REG_DIM_SIZE_1: cfg_q.dim_size[1] <= cfg_data_i;
        stt_pkg::REG_DIM_SIZE_2: cfg_q.dim_size[2] <= cfg_data_i;
        stt_pkg::REG_DIM_SIZE_3: cfg_q.dim_size[3] <= cfg_data_i;
        stt_pkg::REG_STRIDE_0:   cfg_q.stride[0]   <= cfg_data_i[stt_pkg::STRIDE_W-1:0];
        stt_pkg::REG_STRIDE_1:   cfg_q.stride[1]   <= cfg_data_i[stt_pkg::STRIDE_W-1:0];
        stt_pkg::REG_STRIDE_2:   cfg_q.stride[2]   <= cfg_data_i[stt_pkg::STRIDE_W-1:0];
        stt_pkg::REG_STRIDE_3:   cfg_q.stride[3]   <= cfg_data_i[stt_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = start && !busy;
  assign load_we    = accept && (func_i == stt_pkg::FUNC_LOAD)
                      && (load_ptr_q < stt_pkg::LP_W'(stt_pkg::BUF_DEPTH));
  assign ctrl.step  = accept && (func_i == stt_pkg::FUNC_FETCH);
  assign ctrl.clear = accept && (func_i == stt_pkg::FUNC_REWIND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_ptr_q <= '0;
    end else if (ctrl.clear) begin
      load_ptr_q <= '0;
    end else if (load_we) begin
      load_ptr_q <= load_ptr_q + stt_pkg::LP_W'(1);
    end
  end

  stt_addr_gen u_addr_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cfg_i  (cfg_q),
    .addr_o (gen_addr)
  );

  // Any address below the load pointer also fits the buffer.
  assign err_d = gen_addr.addr >= stt_pkg::ADDR_W'(load_ptr_q);

  stt_buffer u_buffer (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (load_ptr_q[stt_pkg::BUF_AW-1:0]),
    .wdata_i (data_in_i),
    .re_i    (rd_en),
    .raddr_i (gen_addr.addr[stt_pkg::BUF_AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    busy    = 1'b1;
    unique case (state_q)
      stt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (ctrl.step) begin
          state_d = stt_pkg::ST_SUM;
        end
      end
      stt_pkg::ST_SUM: begin
        rd_en   = 1'b1;
        state_d = stt_pkg::ST_READ;
      end
      stt_pkg::ST_READ: begin
        state_d = stt_pkg::ST_IDLE;
      end
      default: begin
        state_d = stt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == stt_pkg::ST_SUM) begin
      err_q  <= err_d;
      last_q <= gen_addr.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (state_q == stt_pkg::ST_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == stt_pkg::ST_READ) begin
      data_q     <= err_q ? '0 : rdata;
      out_last_q <= last_q;
      out_err_q  <= err_q;
    end
  end

  assign valid_o       = valid_q;
  assign data_out_o    = data_q;
  assign last_o        = out_last_q;
  assign range_error_o = out_err_q;

  `STT_ASSERT(a_strobe_after_read, clk_i, rst_ni, valid_o |-> $past(state_q == stt_pkg::ST_READ), "result strobe without a buffer read")
  `STT_ASSERT(a_fetch_enters_sum, clk_i, rst_ni, ctrl.step |=> (state_q == stt_pkg::ST_SUM), "accepted fetch did not start the address sum")
  `STT_ASSERT(a_error_gives_zero, clk_i, rst_ni, (valid_o && range_error_o) |-> (data_out_o == '0), "range error with nonzero data")
  `STT_ASSERT(a_busy_holds_ptr, clk_i, rst_ni, busy |=> $stable(load_ptr_q), "load pointer moved while busy")
  `STT_ASSERT(a_ptr_in_range, clk_i, rst_ni, load_ptr_q <= stt_pkg::LP_W'(stt_pkg::BUF_DEPTH), "load pointer beyond buffer depth")

endmodule
